FILE: design/emt_pkg.sv
//------------------------------------------------------------------------------
// emt_pkg
// Shared types and constants for the extent map translator.
//------------------------------------------------------------------------------
`default_nettype none

package emt_pkg;

    localparam int EXTENT_SLOTS = 8;
    localparam int SLOT_W       = $clog2(EXTENT_SLOTS);
    localparam int POS_W        = 48;
    localparam int CNT_W        = 32;
    localparam int OFFS_W       = 20;
    localparam int CAP_W        = 21;
    localparam int TOTAL_W      = 35;
    localparam int DIV_CNT_W    = $clog2(POS_W);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);
    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(1048576);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NOT_MAPPED = 2'd1;
    localparam logic [1:0] STS_NO_SPACE   = 2'd2;
    localparam logic [1:0] STS_OVERFLOW   = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [POS_W-1:0] byte_position;
        logic [POS_W-1:0] base_block;
        logic [CNT_W-1:0] num_blocks;
    } emt_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   physical_block;
        logic [OFFS_W-1:0]  block_offset;
        logic [POS_W-1:0]   logical_index;
        logic [TOTAL_W-1:0] allocated_blocks;
    } emt_out_t;

    typedef struct packed {
        logic              load;
        logic              div_step;
        logic              div_last;
        logic              check;
        logic              walk_step;
        logic [SLOT_W-1:0] slot;
        logic              finish;
    } emt_cmd_t;

    typedef struct packed {
        logic resolved;
    } emt_sts_t;

endpackage

`default_nettype wire

FILE: design/emt_datapath.sv
//------------------------------------------------------------------------------
// emt_datapath
// Extent table, restoring divider, extent walk and result register.
//------------------------------------------------------------------------------
`default_nettype none

module emt_datapath import emt_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data,
    input  wire emt_in_t          in_word,
    input  wire emt_cmd_t         cmd,
    output emt_sts_t              sts,
    output emt_out_t              out_word
);

    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_eff;

    logic [POS_W-1:0]   ext_start_reg [EXTENT_SLOTS];
    logic [CNT_W-1:0]   ext_len_reg   [EXTENT_SLOTS];
    logic [EXTENT_SLOTS-1:0] ext_valid_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [1:0]         op_reg;
    logic [POS_W-1:0]   start_in_reg;
    logic [CNT_W-1:0]   count_in_reg;
    logic [POS_W-1:0]   quot_reg;
    logic [OFFS_W-1:0]  rem_reg;
    logic [POS_W-1:0]   rel_reg;
    logic [POS_W-1:0]   phys_reg;
    logic [1:0]         status_reg;
    logic               resolved_reg;
    emt_out_t           out_reg;

    logic [CAP_W-1:0]   div_r;
    logic [CAP_W-1:0]   div_sub;
    logic               div_ge;
    logic [OFFS_W-1:0]  rem_step;
    logic [POS_W-1:0]   quot_step;

    logic [POS_W-1:0]   rd_start;
    logic [CNT_W-1:0]   rd_len;
    logic               rd_valid;
    logic [POS_W:0]     walk_diff;
    logic               walk_hit;
    logic [POS_W-1:0]   walk_phys;
    logic [POS_W:0]     app_end;
    logic               app_merge;
    logic [CNT_W:0]     app_sum;
    logic [POS_W:0]     chk_sum;
    logic               chk_ovf;
    logic               is_lookup;
    logic               is_append;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (cap_reg > CAP_MAX) begin
            cap_eff = CAP_MAX;
        end else begin
            cap_eff = cap_reg;
        end
    end

    // one quotient bit per step
    assign div_r     = {rem_reg, quot_reg[POS_W-1]};
    assign div_ge    = div_r >= cap_eff;
    assign div_sub   = div_r - cap_eff;
    assign rem_step  = div_ge ? div_sub[OFFS_W-1:0] : div_r[OFFS_W-1:0];
    assign quot_step = {quot_reg[POS_W-2:0], div_ge};

    assign rd_start  = ext_start_reg[cmd.slot];
    assign rd_len    = ext_len_reg[cmd.slot];
    assign rd_valid  = ext_valid_reg[cmd.slot];

    assign walk_diff = {1'b0, rel_reg} - {{(POS_W-CNT_W+1){1'b0}}, rd_len};
    assign walk_hit  = walk_diff[POS_W];
    assign walk_phys = rd_start + rel_reg;

    assign app_end   = {1'b0, rd_start} + {{(POS_W-CNT_W+1){1'b0}}, rd_len};
    assign app_merge = app_end == {1'b0, start_in_reg};
    assign app_sum   = {1'b0, rd_len} + {1'b0, count_in_reg};

    assign chk_sum   = {1'b0, start_in_reg} + {{(POS_W-CNT_W+1){1'b0}}, count_in_reg};
    assign chk_ovf   = chk_sum > {1'b1, {POS_W{1'b0}}};

    assign is_lookup = op_reg == OP_LOOKUP;
    assign is_append = op_reg == OP_APPEND;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            ext_valid_reg <= '0;
            total_reg     <= '0;
            resolved_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                resolved_reg <= 1'b0;
                if (in_word.opcode == OP_CLEAR) begin
                    ext_valid_reg <= '0;
                    total_reg     <= '0;
                end
            end
            if (cmd.check && (count_in_reg == '0 || chk_ovf)) begin
                resolved_reg <= 1'b1;
            end
            if (cmd.walk_step && rd_valid && is_lookup && walk_hit) begin
                resolved_reg <= 1'b1;
            end
            if (cmd.walk_step && is_append) begin
                if (!rd_valid) begin
                    ext_valid_reg[cmd.slot] <= 1'b1;
                    total_reg    <= total_reg + TOTAL_W'(count_in_reg);
                    resolved_reg <= 1'b1;
                end else if (app_merge) begin
                    if (!app_sum[CNT_W]) begin
                        total_reg <= total_reg + TOTAL_W'(count_in_reg);
                    end
                    resolved_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_word.opcode;
            start_in_reg <= in_word.base_block;
            count_in_reg <= in_word.num_blocks;
            quot_reg     <= in_word.byte_position;
            rem_reg      <= '0;
            phys_reg     <= '0;
            unique case (in_word.opcode)
                OP_LOOKUP: status_reg <= STS_NOT_MAPPED;
                OP_APPEND: status_reg <= STS_NO_SPACE;
                default:   status_reg <= STS_OK;
            endcase
        end
        if (cmd.div_step) begin
            quot_reg <= quot_step;
            rem_reg  <= rem_step;
            if (cmd.div_last) begin
                rel_reg <= quot_step;
            end
        end
        if (cmd.check) begin
            if (count_in_reg == '0) begin
                status_reg <= STS_OK;
            end else if (chk_ovf) begin
                status_reg <= STS_OVERFLOW;
            end
        end
        if (cmd.walk_step && rd_valid && is_lookup) begin
            if (walk_hit) begin
                phys_reg   <= walk_phys;
                status_reg <= STS_OK;
            end else begin
                rel_reg <= walk_diff[POS_W-1:0];
            end
        end
        if (cmd.walk_step && is_append) begin
            if (!rd_valid) begin
                ext_start_reg[cmd.slot] <= start_in_reg;
                ext_len_reg[cmd.slot]   <= count_in_reg;
                status_reg              <= STS_OK;
            end else if (app_merge) begin
                if (app_sum[CNT_W]) begin
                    status_reg <= STS_OVERFLOW;
                end else begin
                    ext_len_reg[cmd.slot] <= app_sum[CNT_W-1:0];
                    status_reg            <= STS_OK;
                end
            end
        end
        if (cmd.finish) begin
            out_reg.status           <= status_reg;
            out_reg.physical_block   <= phys_reg;
            out_reg.block_offset     <= is_lookup ? rem_reg : '0;
            out_reg.logical_index    <= is_lookup ? quot_reg : '0;
            out_reg.allocated_blocks <= total_reg;
        end
    end

    assign sts.resolved = resolved_reg;
    assign out_word     = out_reg;

endmodule

`default_nettype wire

FILE: design/emt_ctrl.sv
//------------------------------------------------------------------------------
// emt_ctrl
// Sequencer: divide, check, slot walk and result handoff.
//------------------------------------------------------------------------------
`default_nettype none

module emt_ctrl import emt_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] in_opcode,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire emt_sts_t   sts,
    output emt_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.slot     = slot_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load  = 1'b1;
                    cnt_next  = '0;
                    slot_next = '0;
                    unique case (in_opcode)
                        OP_LOOKUP: state_next = ST_DIV;
                        OP_APPEND: state_next = ST_CHECK;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = cnt_reg == DIV_CNT_W'(POS_W - 1);
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cmd.div_last) begin
                    state_next = ST_WALK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (sts.resolved) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.walk_step = 1'b1;
                    if (slot_reg == SLOT_W'(EXTENT_SLOTS - 1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // result register never overwritten while a word is still waiting
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before handoff");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("finished word not presented");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while busy");

    a_walk_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.walk_step && (cmd.div_step || cmd.check || cmd.load)))
        else $error("walk overlaps another step");

endmodule

`default_nettype wire

FILE: design/extent_map_translator_unit.sv
// Extent map translator: translates a 48-bit file byte position into a
// logical block, offset and physical block through a table of eight extents,
// and appends or clears extents. One word is in flight at a time. A lookup
// runs a one-bit-per-cycle restoring divider by the block data capacity,
// then walks the extent slots, after the word is loaded and before the result
// is handed off. An append takes one range check and then walks the slots;
// clear and the unused opcode go straight from load to handoff. A new word is
// accepted while the previous result still waits in the output register. The
// capacity register is to be written only while the unit is idle; the unit
// itself does not enforce this.
//------------------------------------------------------------------------------
// extent_map_translator_unit
// Top level: controller and datapath.
//------------------------------------------------------------------------------
`default_nettype none

module extent_map_translator_unit import emt_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire emt_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output emt_out_t              m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    emt_cmd_t cmd;
    emt_sts_t sts;

    emt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .in_opcode (s_data.opcode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    emt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_word     (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .out_word    (m_data)
    );

endmodule

`default_nettype wire

FILE: bench/extent_map_translator_unit_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// extent_map_translator_unit_test
// Sends lookup, append, clear and unused-opcode words to the extent map
// translator, with random flow control on both channels for most random traffic. A local copy of the
// extent table and capacity register predicts each result word, and each
// result is checked field by field in order.
//------------------------------------------------------------------------------
module extent_map_translator_unit_test import emt_pkg::*;;

    localparam int          LIMIT_CYCLES = 1_000_000;
    localparam logic [63:0] ADDR_SPAN    = 64'h1_0000_0000_0000;
    localparam logic [63:0] CNT_LIMIT    = 64'hFFFF_FFFF;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    emt_in_t          s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    emt_out_t         m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0] cfg_wr_data = '0;

    logic [POS_W-1:0] slot_start [EXTENT_SLOTS];
    logic [CNT_W-1:0] slot_count [EXTENT_SLOTS];
    logic [CAP_W-1:0] capacity_reg;
    emt_out_t         translations_due [$];
    int               mismatches = 0;
    int               cycles     = 0;
    bit               gaps_on    = 1'b0;
    bit               stalls_on  = 1'b0;

    extent_map_translator_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] block_bytes();
        if (capacity_reg == '0) return 64'd1;
        if (capacity_reg > CAP_MAX) return 64'(CAP_MAX);
        return 64'(capacity_reg);
    endfunction

    function automatic logic [63:0] mapped_blocks();
        logic [63:0] sum;
        sum = '0;
        for (int i = 0; i < EXTENT_SLOTS; i++) sum += 64'(slot_count[i]);
        return sum;
    endfunction

    function automatic logic [1:0] append_extent(input logic [POS_W-1:0] start,
                                                 input logic [CNT_W-1:0] cnt);
        if (cnt == '0) return STS_OK;
        if (64'(start) + 64'(cnt) > ADDR_SPAN) return STS_OVERFLOW;
        for (int i = 0; i < EXTENT_SLOTS; i++) begin
            if (slot_count[i] == '0) begin
                slot_start[i] = start;
                slot_count[i] = cnt;
                return STS_OK;
            end
            if (64'(slot_start[i]) + 64'(slot_count[i]) == 64'(start)) begin
                if (64'(slot_count[i]) + 64'(cnt) > CNT_LIMIT) return STS_OVERFLOW;
                slot_count[i] += cnt;
                return STS_OK;
            end
        end
        return STS_NO_SPACE;
    endfunction

    function automatic emt_out_t apply_extent_op(input emt_in_t w);
        emt_out_t    r;
        logic [63:0] cap, lblk, so_far;
        bit          hit;
        r      = '0;
        hit    = 1'b0;
        so_far = '0;
        case (w.opcode)
            OP_LOOKUP: begin
                cap            = block_bytes();
                lblk           = 64'(w.byte_position) / cap;
                r.logical_index = lblk[POS_W-1:0];
                r.block_offset  = OFFS_W'(64'(w.byte_position) % cap);
                for (int i = 0; i < EXTENT_SLOTS; i++) begin
                    if (!hit && slot_count[i] != '0) begin
                        if (lblk < so_far + 64'(slot_count[i])) begin
                            r.physical_block = POS_W'(64'(slot_start[i]) + (lblk - so_far));
                            hit = 1'b1;
                        end else begin
                            so_far += 64'(slot_count[i]);
                        end
                    end
                end
                r.status = hit ? STS_OK : STS_NOT_MAPPED;
            end
            OP_APPEND: r.status = append_extent(w.base_block, w.num_blocks);
            OP_CLEAR: begin
                slot_start = '{default: '0};
                slot_count = '{default: '0};
            end
            default: ;
        endcase
        r.allocated_blocks = TOTAL_W'(mapped_blocks());
        return r;
    endfunction

    function automatic logic [POS_W-1:0] rand48();
        return POS_W'({$urandom(), $urandom()});
    endfunction

    function automatic emt_in_t make_word(input logic [1:0] op, input logic [POS_W-1:0] pos,
                                          input logic [POS_W-1:0] start,
                                          input logic [CNT_W-1:0] cnt);
        emt_in_t w;
        w.opcode        = op;
        w.byte_position = pos;
        w.base_block    = start;
        w.num_blocks    = cnt;
        return w;
    endfunction

    function automatic emt_in_t random_word();
        emt_in_t     w;
        logic [63:0] span, lblk, pos, tail;
        logic [31:0] cnt;
        int          pick, used, slot;
        w    = make_word(OP_LOOKUP, rand48(), rand48(), $urandom());
        span = mapped_blocks();
        pick = $urandom_range(0, 99);
        used = 0;
        for (int i = 0; i < EXTENT_SLOTS; i++) if (slot_count[i] != '0) used++;
        if (pick < 40) begin
            // land inside the mapped range, or just past it
            if (span != '0) begin
                case ($urandom_range(0, 7))
                    0: lblk = span;
                    1: lblk = span - 1;
                    default: lblk = {$urandom(), $urandom()} % span;
                endcase
                pos = lblk * block_bytes() + ({$urandom(), $urandom()} % block_bytes());
                if (pos < ADDR_SPAN) w.byte_position = pos[POS_W-1:0];
            end
        end else if (pick < 50) begin
            w.byte_position = rand48() >> $urandom_range(0, 47);
        end else if (pick < 76) begin
            w.opcode = OP_APPEND;
            case ($urandom_range(0, 9))
                0: cnt = $urandom();
                1, 2, 3: cnt = $urandom_range(1, 1 << 20);
                default: cnt = $urandom_range(1, 64);
            endcase
            w.num_blocks = cnt;
            w.base_block = rand48() >> $urandom_range(0, 47);
            if (used != 0 && $urandom_range(0, 9) < 4) begin
                slot = $urandom_range(0, used - 1);
                tail = 64'(slot_start[slot]) + 64'(slot_count[slot]);
                if (tail < ADDR_SPAN) w.base_block = tail[POS_W-1:0];
            end
            if (64'(w.base_block) + 64'(cnt) > ADDR_SPAN)
                w.base_block = POS_W'(ADDR_SPAN - 64'(cnt));
        end else if (pick < 82) begin
            w.opcode = OP_APPEND;
            if (used != 0 && $urandom_range(0, 1) == 0) begin
                // merge whose count lands on or just past the 32-bit limit
                slot = $urandom_range(0, used - 1);
                tail = 64'(slot_start[slot]) + 64'(slot_count[slot]);
                w.base_block = tail[POS_W-1:0];
                w.num_blocks = CNT_W'(CNT_LIMIT - 64'(slot_count[slot])
                                      + 64'($urandom_range(0, 2)));
            end else begin
                w.base_block = POS_W'(ADDR_SPAN - 64'($urandom_range(1, 16)));
                w.num_blocks = $urandom_range(1, 24);
            end
        end else if (pick < 86) begin
            w.opcode = OP_CLEAR;
        end else if (pick < 89) begin
            w.opcode = OP_UNUSED;
        end else begin
            w.opcode = 2'($urandom_range(0, 3));
        end
        return w;
    endfunction

    task automatic send_word(input emt_in_t w);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        translations_due.push_back(apply_extent_op(w));
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (translations_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        capacity_reg = v;
    endtask

    task automatic test_directed_table();
        send_word(make_word(OP_LOOKUP, '0, '0, '0));                      // empty table
        send_word(make_word(OP_APPEND, '0, 48'd100, '0));                 // empty append
        send_word(make_word(OP_APPEND, '0, 48'd100, 32'd10));
        send_word(make_word(OP_APPEND, '0, 48'd110, 32'd5));              // merge
        send_word(make_word(OP_APPEND, '0, 48'hFFFF_FFFF_FFFF, 32'd1));   // ends at top
        send_word(make_word(OP_APPEND, '0, 48'hFFFF_FFFF_FFFF, 32'd2));   // start overflow
        send_word(make_word(OP_APPEND, '0, 48'd1000, 32'hFFFF_FFFF));
        send_word(make_word(OP_APPEND, '0, 48'd1000 + 48'hFFFF_FFFF, 32'd1)); // count overflow
        send_word(make_word(OP_LOOKUP, 48'd0, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'd61439, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'd61440, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'd65536, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));      // miss
        for (int i = 0; i < 5; i++)
            send_word(make_word(OP_APPEND, '0, 48'd5000 + 48'(i * 1000), 32'd7));
        send_word(make_word(OP_APPEND, '0, 48'd90000, 32'd3));            // table full
        send_word(make_word(OP_APPEND, '0, 48'd5007, 32'd3));             // merge while full
        send_word(make_word(OP_UNUSED, '1, '1, '1));
        send_word(make_word(OP_CLEAR, '1, '1, '1));
        send_word(make_word(OP_LOOKUP, '0, '0, '0));
    endtask

    task automatic test_capacity_limits();
        set_capacity('0);
        send_word(make_word(OP_APPEND, '0, 48'd7, 32'd20));
        send_word(make_word(OP_LOOKUP, 48'd19, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'd20, '0, '0));
        set_capacity('1);
        send_word(make_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));
        send_word(make_word(OP_LOOKUP, 48'd19922949, '0, '0));
        set_capacity(CAP_MAX);
        send_word(make_word(OP_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0));
        set_capacity(CAP_W'(1));
        send_word(make_word(OP_LOOKUP, 48'd5, '0, '0));
        set_capacity(CAP_RESET);
        send_word(make_word(OP_CLEAR, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input int words);
        for (int n = 0; n < words; n++) begin
            if ($urandom_range(0, 59) == 0) wait_all_results();
            send_word(random_word());
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        emt_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (translations_due.size() == 0) begin
                $error("result word with no translation due");
                mismatches++;
            end else begin
                want = translations_due.pop_front();
                check_field("status", 64'(want.status), 64'(m_data.status));
                check_field("physical_block", 64'(want.physical_block),
                            64'(m_data.physical_block));
                check_field("block_offset", 64'(want.block_offset),
                            64'(m_data.block_offset));
                check_field("logical_index", 64'(want.logical_index),
                            64'(m_data.logical_index));
                check_field("allocated_blocks", 64'(want.allocated_blocks),
                            64'(m_data.allocated_blocks));
            end
        end
    end

    initial begin : result_flow
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (stalls_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("extent_map_translator_unit_test: done, errors");
        $finish;
    end

    initial begin
        slot_start   = '{default: '0};
        slot_count   = '{default: '0};
        capacity_reg = CAP_RESET;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_table();
        test_capacity_limits();

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        test_random_traffic(400);
        set_capacity(CAP_W'(1));
        test_random_traffic(250);
        set_capacity('1);
        test_random_traffic(200);
        set_capacity(CAP_W'($urandom_range(2, 1048575)));
        test_random_traffic(250);
        set_capacity('0);
        test_random_traffic(150);
        set_capacity(CAP_W'(512));
        test_random_traffic(200);

        // no idling on either side from here on
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_capacity(CAP_MAX);
        test_random_traffic(200);

        wait_all_results();
        repeat (64) @(posedge aclk);
        if (mismatches == 0)
            $display("extent_map_translator_unit_test: done, clean");
        else
            $display("extent_map_translator_unit_test: done, errors");
        $finish;
    end

endmodule
